// ----- hw/rtl/mtcqfa_pkg.sv -----
`timescale 1ns / 1ps

package mtcqfa_pkg;

    localparam int TIME_BITS = 48;
    localparam int OFFSET_BITS = 16;
    localparam int NUM_RATES = 4;
    localparam int RATE_BITS = 2;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [7:0] QF_STATUS = 8'hF1;
    localparam logic [1:0] QF_LENGTH = 2'd2;
    localparam logic [7:0] ALL_PIECES = 8'hFF;

    localparam logic [OFFSET_BITS-1:0] RESET_OFFSET_RATE24 = 16'd3500;
    localparam logic [OFFSET_BITS-1:0] RESET_OFFSET_RATE25 = 16'd3360;
    localparam logic [OFFSET_BITS-1:0] RESET_OFFSET_RATE2997 = 16'd2803;
    localparam logic [OFFSET_BITS-1:0] RESET_OFFSET_RATE30 = 16'd2800;

    typedef enum logic [RATE_BITS-1:0] {
        REG_OFFSET_RATE24 = 2'd0,
        REG_OFFSET_RATE25 = 2'd1,
        REG_OFFSET_RATE2997 = 2'd2,
        REG_OFFSET_RATE30 = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        PIECE_FRAME_LO = 3'd0,
        PIECE_FRAME_HI = 3'd1,
        PIECE_SEC_LO = 3'd2,
        PIECE_SEC_HI = 3'd3,
        PIECE_MIN_LO = 3'd4,
        PIECE_MIN_HI = 3'd5,
        PIECE_HOUR_LO = 3'd6,
        PIECE_HOUR_RATE = 3'd7
    } piece_t;

    typedef logic [NUM_RATES-1:0][OFFSET_BITS-1:0] offsets_t;

    // One decoded request held in the input register.
    typedef struct packed {
        logic valid;
        logic is_qf;
        piece_t piece;
        logic [3:0] value;
        logic [TIME_BITS-1:0] event_time;
    } item_t;

endpackage

// ----- hw/rtl/mtcqfa_if.sv -----
`timescale 1ns / 1ps

interface mtcqfa_in_if;
    logic valid;
    logic ready;
    logic [1:0] msg_length;
    logic [7:0] status_byte;
    logic [7:0] data_byte;
    logic [mtcqfa_pkg::TIME_BITS-1:0] block_time;
    logic [15:0] event_offset;

    modport source (
        output valid, msg_length, status_byte, data_byte, block_time, event_offset,
        input ready
    );
    modport sink (
        input valid, msg_length, status_byte, data_byte, block_time, event_offset,
        output ready
    );
endinterface

interface mtcqfa_out_if;
    logic valid;
    logic ready;
    logic [7:0] frame_count;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [4:0] hours;
    logic [1:0] rate_code;
    logic [mtcqfa_pkg::TIME_BITS-1:0] timestamp;

    modport source (
        output valid, frame_count, seconds, minutes, hours, rate_code, timestamp,
        input ready
    );
    modport sink (
        input valid, frame_count, seconds, minutes, hours, rate_code, timestamp,
        output ready
    );
endinterface

// ----- hw/rtl/mtcqfa_cfg.sv -----
`timescale 1ns / 1ps

module mtcqfa_cfg (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [mtcqfa_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [mtcqfa_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [mtcqfa_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                    pready,
    output mtcqfa_pkg::offsets_t                    offsets
);

    mtcqfa_pkg::offsets_t offsets_reg;
    logic [mtcqfa_pkg::RATE_BITS-1:0] index;
    logic write_en;

    assign index = paddr[mtcqfa_pkg::CFG_ADDR_BITS-1:2];
    assign write_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign offsets = offsets_reg;
    assign prdata = {{(mtcqfa_pkg::CFG_DATA_BITS - mtcqfa_pkg::OFFSET_BITS){1'b0}},
                     offsets_reg[index]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg[mtcqfa_pkg::REG_OFFSET_RATE24] <= mtcqfa_pkg::RESET_OFFSET_RATE24;
            offsets_reg[mtcqfa_pkg::REG_OFFSET_RATE25] <= mtcqfa_pkg::RESET_OFFSET_RATE25;
            offsets_reg[mtcqfa_pkg::REG_OFFSET_RATE2997] <=
                mtcqfa_pkg::RESET_OFFSET_RATE2997;
            offsets_reg[mtcqfa_pkg::REG_OFFSET_RATE30] <= mtcqfa_pkg::RESET_OFFSET_RATE30;
        end
        else if (write_en)
        begin
            offsets_reg[index] <= pwdata[mtcqfa_pkg::OFFSET_BITS-1:0];
        end
    end

endmodule

// ----- hw/rtl/mtcqfa_in_stage.sv -----
`timescale 1ns / 1ps

module mtcqfa_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    mtcqfa_in_if.sink             in_ch,
    input  logic                  take,
    output mtcqfa_pkg::item_t     item
);

    logic valid_reg;
    logic valid_next;
    logic is_qf_reg;
    logic [2:0] piece_reg;
    logic [3:0] value_reg;
    logic [mtcqfa_pkg::TIME_BITS-1:0] time_reg;
    logic accept;
    logic is_qf;

    assign in_ch.ready = !valid_reg || take;
    assign accept = in_ch.valid && in_ch.ready;

    // Piece numbers above seven have the top data bit set and are dropped here.
    assign is_qf = (in_ch.msg_length == mtcqfa_pkg::QF_LENGTH)
                && (in_ch.status_byte == mtcqfa_pkg::QF_STATUS)
                && !in_ch.data_byte[7];

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_qf_reg <= is_qf;
            piece_reg <= in_ch.data_byte[6:4];
            value_reg <= in_ch.data_byte[3:0];
            time_reg <= in_ch.block_time
                      + {{(mtcqfa_pkg::TIME_BITS - 16){1'b0}}, in_ch.event_offset};
        end
    end

    assign item.valid = valid_reg;
    assign item.is_qf = is_qf_reg;
    assign item.piece = mtcqfa_pkg::piece_t'(piece_reg);
    assign item.value = value_reg;
    assign item.event_time = time_reg;

endmodule

// ----- hw/rtl/mtcqfa_core.sv -----
`timescale 1ns / 1ps

module mtcqfa_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mtcqfa_pkg::item_t     item,
    input  mtcqfa_pkg::offsets_t  offsets,
    output logic                  take,
    mtcqfa_out_if.source          out_ch
);

    logic [7:0] frame_reg, frame_next;
    logic [7:0] seconds_reg, seconds_next;
    logic [7:0] minutes_reg, minutes_next;
    logic [4:0] hours_reg, hours_next;
    logic [1:0] rate_reg, rate_next;
    logic [7:0] seen_reg, seen_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_frame_reg;
    logic [7:0] out_seconds_reg;
    logic [7:0] out_minutes_reg;
    logic [4:0] out_hours_reg;
    logic [1:0] out_rate_reg;
    logic [mtcqfa_pkg::TIME_BITS-1:0] out_stamp_reg;
    logic [mtcqfa_pkg::TIME_BITS-1:0] stamp;
    logic [7:0] seen_marked;
    logic emit;

    assign take = item.valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        frame_next = frame_reg;
        seconds_next = seconds_reg;
        minutes_next = minutes_reg;
        hours_next = hours_reg;
        rate_next = rate_reg;
        seen_next = seen_reg;
        seen_marked = seen_reg;
        emit = 1'b0;
        if (take && item.is_qf)
        begin
            unique case (item.piece)
                mtcqfa_pkg::PIECE_FRAME_LO: frame_next = {frame_reg[7:4], item.value};
                mtcqfa_pkg::PIECE_FRAME_HI: frame_next = {item.value, frame_reg[3:0]};
                mtcqfa_pkg::PIECE_SEC_LO: seconds_next = {seconds_reg[7:4], item.value};
                mtcqfa_pkg::PIECE_SEC_HI: seconds_next = {item.value, seconds_reg[3:0]};
                mtcqfa_pkg::PIECE_MIN_LO: minutes_next = {minutes_reg[7:4], item.value};
                mtcqfa_pkg::PIECE_MIN_HI: minutes_next = {item.value, minutes_reg[3:0]};
                mtcqfa_pkg::PIECE_HOUR_LO: hours_next = {hours_reg[4], item.value};
                mtcqfa_pkg::PIECE_HOUR_RATE:
                begin
                    hours_next = {item.value[0], hours_reg[3:0]};
                    rate_next = item.value[2:1];
                end
                default: hours_next = hours_reg;
            endcase
            if (item.piece == mtcqfa_pkg::PIECE_HOUR_RATE)
            begin
                seen_marked = seen_reg | 8'd1;
                emit = (seen_marked == mtcqfa_pkg::ALL_PIECES);
            end
            else
            begin
                seen_marked = seen_reg | (8'd2 << item.piece);
            end
            seen_next = emit ? 8'd0 : seen_marked;
        end
    end

    assign stamp = item.event_time
                 - {{(mtcqfa_pkg::TIME_BITS - mtcqfa_pkg::OFFSET_BITS){1'b0}},
                    offsets[rate_next]};

    always_comb
    begin
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= 8'd0;
            seconds_reg <= 8'd0;
            minutes_reg <= 8'd0;
            hours_reg <= 5'd0;
            rate_reg <= 2'd0;
            seen_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg <= frame_next;
            seconds_reg <= seconds_next;
            minutes_reg <= minutes_next;
            hours_reg <= hours_next;
            rate_reg <= rate_next;
            seen_reg <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_frame_reg <= frame_reg;
            out_seconds_reg <= seconds_reg;
            out_minutes_reg <= minutes_reg;
            out_hours_reg <= hours_next;
            out_rate_reg <= rate_next;
            out_stamp_reg <= stamp;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.frame_count = out_frame_reg;
    assign out_ch.seconds = out_seconds_reg;
    assign out_ch.minutes = out_minutes_reg;
    assign out_ch.hours = out_hours_reg;
    assign out_ch.rate_code = out_rate_reg;
    assign out_ch.timestamp = out_stamp_reg;

endmodule

// ----- hw/rtl/mtc_quarter_frame_assembler.sv -----
`timescale 1ns / 1ps

// MIDI time code quarter-frame assembler.
// Requests arrive on in_ch as MIDI events with their sample time; only two-byte
// events with status 0xF1 and a piece number of seven or less change the state.
// Pieces fill the frame, seconds, minutes and hours nibbles and the rate code.
// When the hour and rate piece arrives after the other seven pieces were seen, one
// request leaves on out_ch carrying the assembled timecode and a timestamp equal
// to block_time plus event_offset minus the offset register of the new rate,
// wrapping at the width of the timestamp.
// An accepted input passes one input register and one result register before a
// valid result. One input is accepted every cycle while out_ch does not stall.
// If out_ch stalls, a pending result holds and the input register fills; in_ch
// then drops ready until the result is taken, so nothing is lost.
// The four offset registers sit on the APB port at byte addresses 0, 4, 8 and
// 12, are readable, and should only be written while the block is idle.
// Reset clears the timecode registers, the seen mask and both valid flags, and
// loads the offset registers with their defaults for a 48 kHz sample rate.

module mtc_quarter_frame_assembler (
    input  logic                                    clk,
    input  logic                                    rst_n,
    mtcqfa_in_if.sink                               in_ch,
    mtcqfa_out_if.source                            out_ch,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [mtcqfa_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [mtcqfa_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [mtcqfa_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                    pready
);

    mtcqfa_pkg::offsets_t offsets;
    mtcqfa_pkg::item_t item;
    logic take;

    mtcqfa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .offsets (offsets)
    );

    mtcqfa_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .take  (take),
        .item  (item)
    );

    mtcqfa_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .offsets (offsets),
        .take    (take),
        .out_ch  (out_ch)
    );

endmodule
